// File: rtl/tgarle_pkg.sv
// Shared types and constants for the 24-bit TGA RLE decoder.
package tgarle_pkg;

    // Header layout and the values it must carry
    localparam logic [4:0] HDR_IDX_ID_LEN   = 5'd0;
    localparam logic [4:0] HDR_IDX_CMAP     = 5'd1;
    localparam logic [4:0] HDR_IDX_TYPE     = 5'd2;
    localparam logic [4:0] HDR_IDX_WIDTH_LO = 5'd12;
    localparam logic [4:0] HDR_IDX_WIDTH_HI = 5'd13;
    localparam logic [4:0] HDR_IDX_HGT_LO   = 5'd14;
    localparam logic [4:0] HDR_IDX_HGT_HI   = 5'd15;
    localparam logic [4:0] HDR_IDX_DEPTH    = 5'd16;
    localparam logic [4:0] HDR_IDX_DESC     = 5'd17;
    localparam logic [4:0] HDR_IDX_MAX      = 5'd31;

    localparam logic [7:0] TYPE_RAW         = 8'd2;
    localparam logic [7:0] TYPE_RLE         = 8'd10;
    localparam logic [7:0] DEPTH_24         = 8'd24;
    localparam logic [7:0] HDR_BYTES        = 8'd18;
    localparam logic [7:0] PKT_RUN_MASK     = 8'h80;
    localparam logic [7:0] PKT_COUNT_MASK   = 8'h7F;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_PIXEL    = 3'd0,
        KIND_HDR_OK   = 3'd1,
        KIND_CMAP     = 3'd2,
        KIND_BAD_TYPE = 3'd3,
        KIND_BAD_DEPTH= 3'd4,
        KIND_BAD_DESC = 3'd5,
        KIND_SHORT    = 3'd6
    } t_kind;

    // Parser phases
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_ID     = 2'd1,
        PH_PIXELS = 2'd2,
        PH_IDLE   = 2'd3
    } t_phase;

    // Pixel byte position within a stored BGR triple
    typedef enum logic [1:0] {
        BP_BLUE  = 2'd0,
        BP_GREEN = 2'd1,
        BP_RED   = 2'd2
    } t_byte_phase;

    // One result beat
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] column;
        logic [15:0] row;
        logic [7:0]  run_length;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        last_pixel;
    } t_result;

endpackage

// File: rtl/tgarle_in_stage.sv
// Input register for file byte beats.
module tgarle_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_first_byte,
    input  logic       i_go,
    output logic       o_valid,
    output logic [7:0] o_data_byte,
    output logic       o_first_byte
);

    logic       r_valid;
    logic [7:0] r_data_byte;
    logic       r_first_byte;

    // Take a new beat when empty or when the held one moves on
    assign o_ready = !r_valid || i_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_go) begin
            r_valid <= 1'b0;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data_byte  <= i_data_byte;
            r_first_byte <= i_first_byte;
        end
    end

    assign o_valid      = r_valid;
    assign o_data_byte  = r_data_byte;
    assign o_first_byte = r_first_byte;

endmodule

// File: rtl/tgarle_parser.sv
// Header parser, ID skip and pixel/packet decoder: one byte per cycle on i_go.
module tgarle_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_first_byte,
    input  logic                 i_cfg_wr_en,
    input  logic [31:0]          i_cfg_wr_data,
    output logic                 o_res_valid,
    output tgarle_pkg::t_result  o_res
);

    tgarle_pkg::t_phase      r_phase,    n_phase;
    logic [4:0]              r_hdr_idx,  n_hdr_idx;
    logic [7:0]              r_id_len,   n_id_len;
    logic [7:0]              r_id_left,  n_id_left;
    logic                    r_is_rle,   n_is_rle;
    logic [15:0]             r_width,    n_width;
    logic [15:0]             r_height,   n_height;
    logic [15:0]             r_col,      n_col;
    logic [15:0]             r_row,      n_row;
    logic [7:0]              r_pkt_left, n_pkt_left;
    logic                    r_pkt_run,  n_pkt_run;
    tgarle_pkg::t_byte_phase r_byte_ph,  n_byte_ph;
    logic [7:0]              r_blue,     n_blue;
    logic [7:0]              r_green,    n_green;
    logic [31:0]             r_prod,     n_prod;
    logic [33:0]             r_need,     n_need;
    logic [31:0]             r_total_length;

    tgarle_pkg::t_phase eff_phase;
    logic [4:0]         eff_idx;
    logic [15:0]        hgt_full;
    logic [31:0]        mult;
    logic [16:0]        room;
    logic [7:0]         hdr_len;
    logic [7:0]         px_len;
    logic [16:0]        col_sum;
    logic [15:0]        row_next;
    logic               go_pixels;

    // Length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_length <= 32'd0;
        end else if (i_cfg_wr_en) begin
            r_total_length <= i_cfg_wr_data;
        end
    end

    // Datapath helpers
    assign hgt_full = {i_data_byte, r_height[7:0]};
    assign mult     = hgt_full * r_width;
    assign room     = {1'b0, r_width} - {1'b0, r_col};
    assign go_pixels = (r_width != 16'd0) && (r_height != 16'd0);

    always_comb begin
        hdr_len = {1'b0, i_data_byte[6:0] & tgarle_pkg::PKT_COUNT_MASK[6:0]} + 8'd1;
        if ({9'd0, hdr_len} > room) begin
            hdr_len = room[7:0];
        end
    end

    assign px_len   = (r_is_rle && r_pkt_run) ? r_pkt_left : 8'd1;
    assign col_sum  = {1'b0, r_col} + {9'd0, px_len};
    assign row_next = r_row + 16'd1;

    // Next state and result for the byte in the input register
    always_comb begin
        n_phase    = r_phase;
        n_hdr_idx  = r_hdr_idx;
        n_id_len   = r_id_len;
        n_id_left  = r_id_left;
        n_is_rle   = r_is_rle;
        n_width    = r_width;
        n_height   = r_height;
        n_col      = r_col;
        n_row      = r_row;
        n_pkt_left = r_pkt_left;
        n_pkt_run  = r_pkt_run;
        n_byte_ph  = r_byte_ph;
        n_blue     = r_blue;
        n_green    = r_green;
        n_prod     = r_prod;
        n_need     = r_need;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.kind  = tgarle_pkg::KIND_PIXEL;

        // A marker restarts header parsing in any phase
        eff_phase = i_first_byte ? tgarle_pkg::PH_HEADER : r_phase;
        eff_idx   = i_first_byte ? 5'd0 : r_hdr_idx;

        unique case (eff_phase)
            tgarle_pkg::PH_HEADER: begin
                n_phase   = tgarle_pkg::PH_HEADER;
                n_hdr_idx = (eff_idx < tgarle_pkg::HDR_IDX_MAX) ? eff_idx + 5'd1 : eff_idx;
                unique case (eff_idx)
                    tgarle_pkg::HDR_IDX_ID_LEN: begin
                        n_id_len = i_data_byte;
                    end
                    tgarle_pkg::HDR_IDX_CMAP: begin
                        if (i_data_byte != 8'd0) begin
                            o_res_valid = 1'b1;
                            o_res.kind  = tgarle_pkg::KIND_CMAP;
                            n_phase     = tgarle_pkg::PH_IDLE;
                        end
                    end
                    tgarle_pkg::HDR_IDX_TYPE: begin
                        if (i_data_byte == tgarle_pkg::TYPE_RAW) begin
                            n_is_rle = 1'b0;
                        end else if (i_data_byte == tgarle_pkg::TYPE_RLE) begin
                            n_is_rle = 1'b1;
                        end else begin
                            o_res_valid = 1'b1;
                            o_res.kind  = tgarle_pkg::KIND_BAD_TYPE;
                            n_phase     = tgarle_pkg::PH_IDLE;
                        end
                    end
                    tgarle_pkg::HDR_IDX_WIDTH_LO: n_width  = {r_width[15:8], i_data_byte};
                    tgarle_pkg::HDR_IDX_WIDTH_HI: n_width  = {i_data_byte, r_width[7:0]};
                    tgarle_pkg::HDR_IDX_HGT_LO:   n_height = {r_height[15:8], i_data_byte};
                    tgarle_pkg::HDR_IDX_HGT_HI: begin
                        n_height = hgt_full;
                        n_prod   = mult;
                    end
                    tgarle_pkg::HDR_IDX_DEPTH: begin
                        n_need = {1'b0, r_prod, 1'b0} + {2'd0, r_prod}
                               + {26'd0, tgarle_pkg::HDR_BYTES} + {26'd0, r_id_len};
                        if (i_data_byte != tgarle_pkg::DEPTH_24) begin
                            o_res_valid = 1'b1;
                            o_res.kind  = tgarle_pkg::KIND_BAD_DEPTH;
                            n_phase     = tgarle_pkg::PH_IDLE;
                        end
                    end
                    tgarle_pkg::HDR_IDX_DESC: begin
                        o_res_valid = 1'b1;
                        if (i_data_byte != 8'd0) begin
                            o_res.kind = tgarle_pkg::KIND_BAD_DESC;
                            n_phase    = tgarle_pkg::PH_IDLE;
                        end else if (!r_is_rle && (r_need > {2'd0, r_total_length})) begin
                            o_res.kind = tgarle_pkg::KIND_SHORT;
                            n_phase    = tgarle_pkg::PH_IDLE;
                        end else begin
                            o_res.kind         = tgarle_pkg::KIND_HDR_OK;
                            o_res.image_width  = r_width;
                            o_res.image_height = r_height;
                            if (r_id_len != 8'd0) begin
                                n_id_left = r_id_len;
                                n_phase   = tgarle_pkg::PH_ID;
                            end else begin
                                n_col      = 16'd0;
                                n_row      = 16'd0;
                                n_pkt_left = 8'd0;
                                n_pkt_run  = 1'b0;
                                n_byte_ph  = tgarle_pkg::BP_BLUE;
                                n_phase    = go_pixels ? tgarle_pkg::PH_PIXELS
                                                       : tgarle_pkg::PH_IDLE;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            tgarle_pkg::PH_ID: begin
                // Skip the ID field
                n_id_left = r_id_left - 8'd1;
                if (r_id_left == 8'd1) begin
                    n_col      = 16'd0;
                    n_row      = 16'd0;
                    n_pkt_left = 8'd0;
                    n_pkt_run  = 1'b0;
                    n_byte_ph  = tgarle_pkg::BP_BLUE;
                    n_phase    = go_pixels ? tgarle_pkg::PH_PIXELS : tgarle_pkg::PH_IDLE;
                end
            end
            tgarle_pkg::PH_PIXELS: begin
                if (r_is_rle && (r_pkt_left == 8'd0)) begin
                    // Packet header: clip count at the row end
                    n_pkt_left = hdr_len;
                    n_pkt_run  = (i_data_byte & tgarle_pkg::PKT_RUN_MASK) != 8'd0;
                    n_byte_ph  = tgarle_pkg::BP_BLUE;
                end else begin
                    unique case (r_byte_ph)
                        tgarle_pkg::BP_BLUE: begin
                            n_blue    = i_data_byte;
                            n_byte_ph = tgarle_pkg::BP_GREEN;
                        end
                        tgarle_pkg::BP_GREEN: begin
                            n_green   = i_data_byte;
                            n_byte_ph = tgarle_pkg::BP_RED;
                        end
                        default: begin
                            // Third byte completes the pixel: emit the run
                            n_byte_ph        = tgarle_pkg::BP_BLUE;
                            o_res_valid      = 1'b1;
                            o_res.kind       = tgarle_pkg::KIND_PIXEL;
                            o_res.red        = i_data_byte;
                            o_res.green      = r_green;
                            o_res.blue       = r_blue;
                            o_res.column     = r_col;
                            o_res.row        = r_height - 16'd1 - r_row;
                            o_res.run_length = px_len;
                            if (r_is_rle) begin
                                n_pkt_left = r_pkt_left - px_len;
                            end
                            if (col_sum >= {1'b0, r_width}) begin
                                n_col = 16'd0;
                                n_row = row_next;
                                if (row_next >= r_height) begin
                                    o_res.last_pixel = 1'b1;
                                    n_phase          = tgarle_pkg::PH_IDLE;
                                end
                            end else begin
                                n_col = col_sum[15:0];
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= tgarle_pkg::PH_HEADER;
            r_hdr_idx  <= 5'd0;
            r_id_len   <= 8'd0;
            r_id_left  <= 8'd0;
            r_is_rle   <= 1'b0;
            r_width    <= 16'd0;
            r_height   <= 16'd0;
            r_col      <= 16'd0;
            r_row      <= 16'd0;
            r_pkt_left <= 8'd0;
            r_pkt_run  <= 1'b0;
            r_byte_ph  <= tgarle_pkg::BP_BLUE;
            r_blue     <= 8'd0;
            r_green    <= 8'd0;
        end else if (i_go) begin
            r_phase    <= n_phase;
            r_hdr_idx  <= n_hdr_idx;
            r_id_len   <= n_id_len;
            r_id_left  <= n_id_left;
            r_is_rle   <= n_is_rle;
            r_width    <= n_width;
            r_height   <= n_height;
            r_col      <= n_col;
            r_row      <= n_row;
            r_pkt_left <= n_pkt_left;
            r_pkt_run  <= n_pkt_run;
            r_byte_ph  <= n_byte_ph;
            r_blue     <= n_blue;
            r_green    <= n_green;
        end
    end

    // Size check pipeline over header bytes
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_prod <= n_prod;
            r_need <= n_need;
        end
    end

endmodule

// File: rtl/tgarle_out_stage.sv
// Result register for decoded beats.
module tgarle_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic                i_res_valid,
    input  tgarle_pkg::t_result i_res,
    input  logic                i_ready,
    output logic                o_valid,
    output logic                o_free,
    output tgarle_pkg::t_result o_res
);

    logic                r_valid;
    tgarle_pkg::t_result r_res;

    // Room for a new result when empty or being taken
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res_valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Hold payload until taken
    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: rtl/tga_rle_truecolor_decoder_top.sv
// Top level of the 24-bit TGA RLE decoder.
// Takes one file byte per beat and returns status beats (header accepted or the
// rejection cause) and pixel-run beats with colour, column, flipped row and run
// length. Throughput is one byte per cycle while results are taken without stall;
// each byte's parser update is combinational between the input register and the
// result register, so its result is loaded into the result register as the byte
// leaves the input register. The uncompressed size check is spread over header
// bytes 15 to 17: the width-by-height product is registered at byte 15, the byte
// total at byte 16, compared at byte 17. The user must write total_length through
// the write port only while no byte is in flight; the block does not enforce it.
module tga_rle_truecolor_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [15:0] o_column,
    output logic [15:0] o_row,
    output logic [7:0]  o_run_length,
    output logic [15:0] o_image_width,
    output logic [15:0] o_image_height,
    output logic        o_last_pixel
);

    logic                s_in_valid;
    logic [7:0]          s_in_byte;
    logic                s_in_first;
    logic                s_go;
    logic                s_out_free;
    logic                s_res_valid;
    tgarle_pkg::t_result s_res;
    tgarle_pkg::t_result s_out;

    // Advance the held byte when the result register has room
    assign s_go = s_in_valid && s_out_free;

    tgarle_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_go         (s_go),
        .o_valid      (s_in_valid),
        .o_data_byte  (s_in_byte),
        .o_first_byte (s_in_first)
    );

    tgarle_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (s_go),
        .i_data_byte   (s_in_byte),
        .i_first_byte  (s_in_first),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_res_valid   (s_res_valid),
        .o_res         (s_res)
    );

    tgarle_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (s_go),
        .i_res_valid (s_res_valid),
        .i_res       (s_res),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_free      (s_out_free),
        .o_res       (s_out)
    );

    assign o_kind         = s_out.kind;
    assign o_red          = s_out.red;
    assign o_green        = s_out.green;
    assign o_blue         = s_out.blue;
    assign o_column       = s_out.column;
    assign o_row          = s_out.row;
    assign o_run_length   = s_out.run_length;
    assign o_image_width  = s_out.image_width;
    assign o_image_height = s_out.image_height;
    assign o_last_pixel   = s_out.last_pixel;

endmodule

// File: rtl/tgarle_checker.sv
// Port-level checks on the decoder's result channel, bound to the top level.
module tgarle_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_kind,
    input logic [7:0]  o_run_length,
    input logic [15:0] o_image_width,
    input logic [15:0] o_image_height,
    input logic        o_last_pixel
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_run_length))
        else $error("result beat dropped or changed while stalled");

    // Drop any result beat on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat present after reset");

    // Status beats carry no run
    a_status_no_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind != tgarle_pkg::KIND_PIXEL) |-> (o_run_length == 8'd0) && !o_last_pixel)
        else $error("status beat carries a run");

    // Pixel beats cover one to 128 pixels
    a_pixel_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == tgarle_pkg::KIND_PIXEL) |->
            (o_run_length != 8'd0) && (o_run_length <= 8'd128))
        else $error("pixel beat with bad run length");

    // Dimensions appear only with header accepted
    a_dims_hdr_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind != tgarle_pkg::KIND_HDR_OK) |->
            (o_image_width == 16'd0) && (o_image_height == 16'd0))
        else $error("dimensions on a beat other than header accepted");

endmodule

bind tga_rle_truecolor_decoder_top tgarle_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_kind         (o_kind),
    .o_run_length   (o_run_length),
    .o_image_width  (o_image_width),
    .o_image_height (o_image_height),
    .o_last_pixel   (o_last_pixel)
);

// File: dv/tb_tga_rle_truecolor_decoder_top.sv
// Self-checking testbench for the 24-bit TGA RLE decoder top level.
module tb_tga_rle_truecolor_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tgarle_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int PHASE_ITEMS = 175;
    localparam int N_PHASES    = 8;

    // Block ports
    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [31:0] i_cfg_wr_data = '0;
    logic        i_valid       = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte   = '0;
    logic        i_first_byte  = 1'b0;
    logic        o_valid;
    logic        i_ready       = 1'b1;
    logic [2:0]  o_kind;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [15:0] o_column;
    logic [15:0] o_row;
    logic [7:0]  o_run_length;
    logic [15:0] o_image_width;
    logic [15:0] o_image_height;
    logic        o_last_pixel;

    tga_rle_truecolor_decoder_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_first_byte   (i_first_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_column       (o_column),
        .o_row          (o_row),
        .o_run_length   (o_run_length),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height),
        .o_last_pixel   (o_last_pixel)
    );

    // Decoder state mirrored by the predictor
    t_phase      dec_phase = PH_HEADER;
    logic [4:0]  hdr_pos   = '0;
    logic [7:0]  id_len    = '0;
    logic [7:0]  id_left   = '0;
    logic        rle_mode  = 1'b0;
    logic [15:0] img_w     = '0;
    logic [15:0] img_h     = '0;
    logic [15:0] col_cnt   = '0;
    logic [15:0] row_cnt   = '0;
    logic [7:0]  pkt_left  = '0;
    logic        pkt_run   = 1'b0;
    t_byte_phase bgr_pos   = BP_BLUE;
    logic [7:0]  hold_b    = '0;
    logic [7:0]  hold_g    = '0;
    logic [31:0] file_len  = '0;

    t_result decoded_q[$];
    int      mismatches   = 0;
    int      live_items   = 0;
    int      quiet_cycles = 0;
    int      gap_pct      = 0;
    int      stall_pct    = 0;

    // Status written out by hand for the next directed byte
    bit      status_typed = 1'b0;
    t_kind   status_kind  = KIND_PIXEL;

    // Directed stimulus: byte, marker, typed status, status kind
    typedef struct {
        logic [7:0] data;
        logic       first;
        bit         typed;
        t_kind      kind;
    } t_row;

    t_row dir_rows [27] = '{
        '{8'h00, 1'b0, 1'b0, KIND_PIXEL},     // header parsed from reset with no marker
        '{8'h01, 1'b0, 1'b1, KIND_CMAP},
        '{8'hFF, 1'b0, 1'b0, KIND_PIXEL},     // ignored after rejection
        '{8'h00, 1'b1, 1'b0, KIND_PIXEL},
        '{8'h00, 1'b0, 1'b0, KIND_PIXEL},
        '{8'h0B, 1'b0, 1'b1, KIND_BAD_TYPE},
        '{8'h03, 1'b1, 1'b0, KIND_PIXEL},     // header abandoned by the next marker
        '{8'h00, 1'b0, 1'b0, KIND_PIXEL},
        '{8'h0A, 1'b0, 1'b0, KIND_PIXEL},
        '{8'hFF, 1'b1, 1'b0, KIND_PIXEL},     // longest ID field, raw type
        '{8'h00, 1'b0, 1'b0, KIND_PIXEL},
        '{8'h02, 1'b0, 1'b0, KIND_PIXEL},
        '{8'hFF, 1'b0, 1'b0, KIND_PIXEL},
        '{8'h00, 1'b0, 1'b0, KIND_PIXEL},
        '{8'hFF, 1'b0, 1'b0, KIND_PIXEL},
        '{8'h00, 1'b0, 1'b0, KIND_PIXEL},
        '{8'hFF, 1'b0, 1'b0, KIND_PIXEL},
        '{8'h00, 1'b0, 1'b0, KIND_PIXEL},
        '{8'hFF, 1'b0, 1'b0, KIND_PIXEL},
        '{8'h00, 1'b0, 1'b0, KIND_PIXEL},
        '{8'hFF, 1'b0, 1'b0, KIND_PIXEL},
        '{8'hFF, 1'b0, 1'b0, KIND_PIXEL},     // width and height at their maximum
        '{8'hFF, 1'b0, 1'b0, KIND_PIXEL},
        '{8'hFF, 1'b0, 1'b0, KIND_PIXEL},
        '{8'hFF, 1'b0, 1'b0, KIND_PIXEL},
        '{8'h18, 1'b0, 1'b0, KIND_PIXEL},
        '{8'h80, 1'b0, 1'b1, KIND_BAD_DESC}
    };

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Reset pixel decoding at the end of the header or ID field
    function automatic void start_pixels();
        col_cnt  = '0;
        row_cnt  = '0;
        pkt_left = '0;
        pkt_run  = 1'b0;
        bgr_pos  = BP_BLUE;
        dec_phase = (img_w == 0 || img_h == 0) ? PH_IDLE : PH_PIXELS;
    endfunction

    function automatic bit stop_with(output t_result r, input t_kind k);
        r = '0;
        r.kind = k;
        dec_phase = PH_IDLE;
        return 1'b1;
    endfunction

    // Advance the decoder by one file byte; return 1 when it yields a beat
    function automatic bit decode_byte(input logic [7:0] b, input logic f,
                                       output t_result r);
        logic [4:0]  pos;
        logic [63:0] need;
        int unsigned len;
        int unsigned room;
        int unsigned col;
        r = '0;
        if (f) begin
            dec_phase = PH_HEADER;
            hdr_pos   = '0;
        end
        case (dec_phase)
            PH_HEADER: begin
                pos = hdr_pos;
                if (hdr_pos != HDR_IDX_MAX) hdr_pos = hdr_pos + 5'd1;
                case (pos)
                    HDR_IDX_ID_LEN:   id_len = b;
                    HDR_IDX_CMAP:     if (b != 0) return stop_with(r, KIND_CMAP);
                    HDR_IDX_TYPE: begin
                        if (b == TYPE_RAW) rle_mode = 1'b0;
                        else if (b == TYPE_RLE) rle_mode = 1'b1;
                        else return stop_with(r, KIND_BAD_TYPE);
                    end
                    HDR_IDX_WIDTH_LO: img_w[7:0]  = b;
                    HDR_IDX_WIDTH_HI: img_w[15:8] = b;
                    HDR_IDX_HGT_LO:   img_h[7:0]  = b;
                    HDR_IDX_HGT_HI:   img_h[15:8] = b;
                    HDR_IDX_DEPTH:    if (b != DEPTH_24) return stop_with(r, KIND_BAD_DEPTH);
                    HDR_IDX_DESC: begin
                        if (b != 0) return stop_with(r, KIND_BAD_DESC);
                        // widen before multiplying so huge images cannot wrap
                        need = 64'(HDR_BYTES) + 64'(id_len) + 64'd3 * 64'(img_w) * 64'(img_h);
                        if (!rle_mode && need > 64'(file_len)) return stop_with(r, KIND_SHORT);
                        r.kind         = KIND_HDR_OK;
                        r.image_width  = img_w;
                        r.image_height = img_h;
                        if (id_len != 0) begin
                            id_left   = id_len;
                            dec_phase = PH_ID;
                        end else begin
                            start_pixels();
                        end
                        return 1'b1;
                    end
                    default: ;
                endcase
                return 1'b0;
            end
            PH_ID: begin
                id_left = id_left - 8'd1;
                if (id_left == 0) start_pixels();
                return 1'b0;
            end
            PH_PIXELS: begin
                // packet header: clip the count at the row end
                if (rle_mode && pkt_left == 0) begin
                    len  = int'(b & PKT_COUNT_MASK) + 1;
                    room = 32'(img_w) - 32'(col_cnt);
                    if (len > room) len = room;
                    pkt_left = 8'(len);
                    pkt_run  = (b & PKT_RUN_MASK) != 0;
                    bgr_pos  = BP_BLUE;
                    return 1'b0;
                end
                if (bgr_pos == BP_BLUE) begin
                    hold_b  = b;
                    bgr_pos = BP_GREEN;
                    return 1'b0;
                end
                if (bgr_pos == BP_GREEN) begin
                    hold_g  = b;
                    bgr_pos = BP_RED;
                    return 1'b0;
                end
                bgr_pos = BP_BLUE;
                len = (rle_mode && pkt_run) ? int'(pkt_left) : 1;
                r.kind       = KIND_PIXEL;
                r.red        = b;
                r.green      = hold_g;
                r.blue       = hold_b;
                r.column     = col_cnt;
                r.row        = img_h - 16'd1 - row_cnt;
                r.run_length = 8'(len);
                if (rle_mode) pkt_left = pkt_left - 8'(len);
                col = 32'(col_cnt) + len;
                if (col >= img_w) begin
                    col_cnt = '0;
                    row_cnt = row_cnt + 16'd1;
                    if (row_cnt >= img_h) begin
                        r.last_pixel = 1'b1;
                        dec_phase    = PH_IDLE;
                    end
                end else begin
                    col_cnt = 16'(col);
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Take result beats, compare with the oldest prediction, and stall at random
    always @(posedge i_clk) begin : take_result
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (decoded_q.size() == 0) begin
                $error("result beat with nothing predicted: kind %0d", o_kind);
                mismatches++;
            end else begin
                want = decoded_q.pop_front();
                check_field("kind",         16'(want.kind),       16'(o_kind));
                check_field("red",          16'(want.red),        16'(o_red));
                check_field("green",        16'(want.green),      16'(o_green));
                check_field("blue",         16'(want.blue),       16'(o_blue));
                check_field("column",       want.column,          o_column);
                check_field("row",          want.row,             o_row);
                check_field("run_length",   16'(want.run_length), 16'(o_run_length));
                check_field("image_width",  want.image_width,     o_image_width);
                check_field("image_height", want.image_height,    o_image_height);
                check_field("last_pixel",   16'(want.last_pixel), 16'(o_last_pixel));
            end
        end
        i_ready <= ($urandom_range(99, 0) >= stall_pct);
    end

    // Count cycles in which no beat moves on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("tb_tga_rle_truecolor_decoder_top: errors");
        $finish;
    end

    // Offer one byte, hold it until accepted, then predict its outcome
    task automatic send_byte(input logic [7:0] b, input logic f);
        t_result res;
        bit      got;
        while ($urandom_range(99, 0) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data_byte  <= b;
        i_first_byte <= f;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (f || dec_phase != PH_IDLE) live_items++;
        got = decode_byte(b, f, res);
        if (status_typed) begin
            res          = '0;
            res.kind     = status_kind;
            got          = 1'b1;
            status_typed = 1'b0;
        end
        if (got) decoded_q.push_back(res);
    endtask

    // Stop sending and wait for every predicted beat
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_total_length(input logic [31:0] v);
        drain_results();
        repeat (8) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        file_len = v;
    endtask

    // Send the first stop_at bytes of an 18-byte header
    task automatic send_header(input logic [7:0] id, input logic [7:0] cmap,
                               input logic [7:0] ity, input logic [15:0] w,
                               input logic [15:0] h, input logic [7:0] depth,
                               input logic [7:0] desc, input int stop_at);
        logic [7:0] b;
        for (int k = 0; k < stop_at && k < 18; k++) begin
            case (5'(k))
                HDR_IDX_ID_LEN:   b = id;
                HDR_IDX_CMAP:     b = cmap;
                HDR_IDX_TYPE:     b = ity;
                HDR_IDX_WIDTH_LO: b = w[7:0];
                HDR_IDX_WIDTH_HI: b = w[15:8];
                HDR_IDX_HGT_LO:   b = h[7:0];
                HDR_IDX_HGT_HI:   b = h[15:8];
                HDR_IDX_DEPTH:    b = depth;
                HDR_IDX_DESC:     b = desc;
                default:          b = 8'($urandom);
            endcase
            send_byte(b, k == 0);
        end
    endtask

    // Feed ID and pixel bytes, shaping packet headers, until the image ends
    task automatic send_body(input int max_bytes);
        int         n;
        logic [7:0] pkt;
        int         r;
        n = 0;
        while ((dec_phase == PH_ID || dec_phase == PH_PIXELS) && n < max_bytes) begin
            if (dec_phase == PH_PIXELS && rle_mode && pkt_left == 0) begin
                r = $urandom_range(99, 0);
                pkt[7]   = 1'($urandom_range(1, 0));
                pkt[6:0] = (r < 65) ? 7'($urandom_range(3, 0)) :
                           (r < 85) ? 7'($urandom_range(15, 0)) :
                           (r < 93) ? 7'($urandom) : PKT_COUNT_MASK[6:0];
                send_byte(pkt, 1'b0);
            end else begin
                send_byte(8'($urandom), 1'b0);
            end
            n++;
        end
    endtask

    function automatic logic [7:0] pick_id_length();
        int r;
        r = $urandom_range(99, 0);
        if (r < 78) return 8'd0;
        if (r < 96) return 8'($urandom_range(4, 1));
        if (r < 98) return 8'hFF;
        return 8'($urandom_range(255, 1));
    endfunction

    // One file, well formed or broken, followed now and then by stray bytes
    task automatic send_file();
        int          pick;
        int          cause;
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0]  id;
        logic [7:0]  ity;
        logic [7:0]  cmap;
        logic [7:0]  depth;
        logic [7:0]  desc;
        longint      slack;
        pick  = $urandom_range(99, 0);
        w     = 16'($urandom_range(6, 1));
        h     = 16'($urandom_range(4, 1));
        if ($urandom_range(3, 0) == 0) w = 16'($urandom_range(40, 1));
        id    = pick_id_length();
        ity   = $urandom_range(1, 0) ? TYPE_RLE : TYPE_RAW;
        cmap  = 8'd0;
        depth = DEPTH_24;
        desc  = 8'd0;
        if (pick < 45) begin
            send_header(id, cmap, TYPE_RLE, w, h, depth, desc, 18);
            send_body(1 << 20);
        end else if (pick < 60) begin
            send_header(id, cmap, TYPE_RAW, w, h, depth, desc, 18);
            send_body(1 << 20);
        end else if (pick < 68) begin
            // one header field out of range
            cause = $urandom_range(3, 0);
            if (cause == 0) cmap = 8'($urandom_range(255, 1));
            if (cause == 1) begin
                ity = 8'($urandom);
                if (ity == TYPE_RAW || ity == TYPE_RLE) ity = 8'hFF;
            end
            if (cause == 2) begin
                depth = 8'($urandom);
                if (depth == DEPTH_24) depth = 8'h00;
            end
            if (cause == 3) desc = 8'($urandom_range(255, 1));
            send_header(id, cmap, ity, w, h, depth, desc, 18);
            send_body(1 << 20);
        end else if (pick < 73) begin
            // empty image: width, height or both zero
            cause = $urandom_range(2, 0);
            if (cause != 1) w = '0;
            if (cause != 0) h = '0;
            send_header(id, cmap, ity, w, h, depth, desc, 18);
        end else if (pick < 78) begin
            // huge dimensions, abandoned part way through the pixels
            w = $urandom_range(1, 0) ? 16'hFFFF : 16'($urandom_range(65535, 1));
            h = $urandom_range(1, 0) ? 16'hFFFF : 16'($urandom_range(65535, 1));
            send_header(id, cmap, ity, w, h, depth, desc, 18);
            send_body($urandom_range(40, 0));
        end else if (pick < 85) begin
            send_header(id, cmap, ity, w, h, depth, desc, 18);
            send_body($urandom_range(20, 0));
        end else if (pick < 90) begin
            send_header(id, cmap, ity, w, h, depth, desc, $urandom_range(17, 1));
        end else if (pick < 95) begin
            repeat ($urandom_range(8, 1)) send_byte(8'($urandom), $urandom_range(9, 0) == 0);
        end else begin
            // raw image sized right at the declared length, or one byte over
            slack = longint'(file_len) - 18 - 3 * longint'(w) * longint'(h);
            if (slack >= 0 && slack <= 255) begin
                id = 8'(slack);
                if (slack < 255 && $urandom_range(1, 0) == 1) id = id + 8'd1;
            end
            send_header(id, cmap, TYPE_RAW, w, h, depth, desc, 18);
            send_body(1 << 20);
        end
        if ($urandom_range(3, 0) == 0)
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom), 1'b0);
    endtask

    // Main sequence
    initial begin
        int          gap_plan [4];
        int          stall_plan [4];
        logic [31:0] len_plan [N_PHASES];
        gap_plan   = '{0, 68, 0, 6};
        stall_plan = '{0, 0, 68, 6};
        len_plan   = '{32'd0, 32'hFFFF_FFFF, 32'($urandom_range(200, 60)), 32'd0,
                       32'($urandom_range(200, 60)), 32'hFFFF_FFFF,
                       32'($urandom_range(200, 60)), 32'($urandom_range(200, 60))};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed bytes
        foreach (dir_rows[k]) begin
            status_typed = dir_rows[k].typed;
            status_kind  = dir_rows[k].kind;
            send_byte(dir_rows[k].data, dir_rows[k].first);
        end

        // Random files across idling modes and declared lengths
        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph != 0) write_total_length(len_plan[ph]);
            gap_pct   = gap_plan[ph % 4];
            stall_pct = stall_plan[ph % 4];
            while (live_items < (ph + 1) * PHASE_ITEMS) begin
                send_file();
                if ($urandom_range(24, 0) == 0) drain_results();
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_tga_rle_truecolor_decoder_top: clean");
        end else begin
            $display("tb_tga_rle_truecolor_decoder_top: errors");
        end
        $finish;
    end

endmodule
